@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL, included by the controller. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define AST_IMPL(lbl, clk, rstn, ante, cons, msg)
`define AST_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ hdl/sukset_pkg.sv @@
package sukset_pkg;

  localparam int KEY_W   = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_SEARCH,
    OP_LIST
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_DUP,
    STAT_NOTFOUND,
    STAT_FULL,
    STAT_EMPTY
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_act_t;

  typedef struct packed {
    cell_act_t               act;
    logic signed [KEY_W-1:0] key;
  } cell_cmd_t;

  typedef enum logic {
    CTRL_IDLE,
    CTRL_LIST
  } ctrl_state_t;

endpackage

@@ hdl/sorted_unique_key_set_top.sv @@
// Sorted set of up to CAPACITY distinct signed 32-bit keys, held in a chain of cells,
// each cell comparing its key with the request in parallel. A request is taken when
// start is high and busy is low. Insert, delete and search give one result in the
// cycle after the request and busy stays low, so a request may follow every cycle.
// List of n keys raises busy during the list state and gives n results on consecutive
// cycles, each registered from the head cell as the chain rotates one place per cycle;
// an empty list gives one result in the next cycle. Results are strobed by out_valid
// for a single cycle and cannot be held off by the receiver.
module sorted_unique_key_set_top #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sukset_pkg::OP_W-1:0]         in_opcode,
  input  logic signed [sukset_pkg::KEY_W-1:0] in_key,
  output logic                                out_valid,
  output logic [sukset_pkg::STAT_W-1:0]       out_status,
  output logic signed [sukset_pkg::KEY_W-1:0] out_key,
  output logic                                out_last,
  output logic [sukset_pkg::COUNT_W-1:0]      out_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  sukset_pkg::cell_cmd_t               cmd;
  logic [CW-1:0]                       count;
  logic signed [sukset_pkg::KEY_W-1:0] key_w [CAPACITY];
  logic [CAPACITY-1:0]                 less_w;
  logic [CAPACITY-1:0]                 hit_w;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int P = (i == 0) ? 0 : i - 1;
    localparam int N = (i == CAPACITY - 1) ? i : i + 1;

    sukset_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .prev_key  (key_w[P]),
      .prev_less ((i == 0) ? 1'b1 : less_w[P]),
      .next_key  (key_w[N]),
      .head_key  (key_w[0]),
      .key_o     (key_w[i]),
      .less_o    (less_w[i]),
      .hit_o     (hit_w[i])
    );
  end

  sukset_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_opcode  (in_opcode),
    .in_key     (in_key),
    .hit        (|hit_w),
    .head_key   (key_w[0]),
    .cmd        (cmd),
    .count      (count),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_key    (out_key),
    .out_last   (out_last),
    .out_count  (out_count)
  );

endmodule

@@ hdl/sukset_cell.sv @@
module sukset_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  sukset_pkg::cell_cmd_t              cmd,
  input  logic [CW-1:0]                      count,
  input  logic signed [sukset_pkg::KEY_W-1:0] prev_key,
  input  logic                               prev_less,
  input  logic signed [sukset_pkg::KEY_W-1:0] next_key,
  input  logic signed [sukset_pkg::KEY_W-1:0] head_key,
  output logic signed [sukset_pkg::KEY_W-1:0] key_o,
  output logic                               less_o,
  output logic                               hit_o
);

  logic signed [sukset_pkg::KEY_W-1:0] key_r;
  logic signed [sukset_pkg::KEY_W-1:0] key_nxt;
  logic                                valid;
  logic                                next_valid;

  // occupancy is a prefix of the chain, so it follows from the count
  assign valid      = count > CW'(IDX);
  assign next_valid = count > CW'(IDX + 1);

  assign less_o = valid && (key_r < cmd.key);
  assign hit_o  = valid && (key_r == cmd.key);
  assign key_o  = key_r;

  always_comb begin
    key_nxt = key_r;
    case (cmd.act)
      sukset_pkg::CELL_INS: begin
        // cells at or above the insertion point move up one place
        if (!less_o) begin
          key_nxt = prev_less ? cmd.key : prev_key;
        end
      end
      sukset_pkg::CELL_DEL: begin
        if (valid && !less_o) begin
          key_nxt = next_key;
        end
      end
      sukset_pkg::CELL_ROT: begin
        // rotate the occupied prefix; the tail picks up the head
        if (valid) begin
          key_nxt = next_valid ? next_key : head_key;
        end
      end
      default: key_nxt = key_r;
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

@@ hdl/sukset_ctrl.sv @@
`include "assert_macros.svh"

module sukset_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CW       = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sukset_pkg::OP_W-1:0]         in_opcode,
  input  logic signed [sukset_pkg::KEY_W-1:0] in_key,
  input  logic                                hit,
  input  logic signed [sukset_pkg::KEY_W-1:0] head_key,
  output sukset_pkg::cell_cmd_t               cmd,
  output logic [CW-1:0]                       count,
  output logic                                out_valid,
  output logic [sukset_pkg::STAT_W-1:0]       out_status,
  output logic signed [sukset_pkg::KEY_W-1:0] out_key,
  output logic                                out_last,
  output logic [sukset_pkg::COUNT_W-1:0]      out_count
);

  sukset_pkg::ctrl_state_t state_r, state_nxt;
  sukset_pkg::opcode_t     op;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          accept;
  logic          full;
  logic          empty;

  logic                                out_valid_r, out_valid_nxt;
  sukset_pkg::status_t                 out_status_r, out_status_nxt;
  logic signed [sukset_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  logic                                out_last_r, out_last_nxt;
  logic [sukset_pkg::COUNT_W-1:0]      out_count_r, out_count_nxt;

  assign op     = sukset_pkg::opcode_t'(in_opcode);
  assign busy   = (state_r != sukset_pkg::CTRL_IDLE);
  assign accept = start && !busy;
  assign full   = (count_r == CW'(CAPACITY));
  assign empty  = (count_r == '0);
  assign count  = count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sukset_pkg::CTRL_IDLE: begin
        if (accept && op == sukset_pkg::OP_LIST && !empty) begin
          state_nxt = sukset_pkg::CTRL_LIST;
        end
      end
      sukset_pkg::CTRL_LIST: begin
        if (left_r == CW'(1)) begin
          state_nxt = sukset_pkg::CTRL_IDLE;
        end
      end
      default: state_nxt = sukset_pkg::CTRL_IDLE;
    endcase
  end

  // cell command, counters and result
  always_comb begin
    cmd.act        = sukset_pkg::CELL_HOLD;
    cmd.key        = in_key;
    count_nxt      = count_r;
    left_nxt       = left_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = sukset_pkg::STAT_OK;
    out_key_nxt    = in_key;
    out_last_nxt   = 1'b1;
    case (state_r)
      sukset_pkg::CTRL_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (op)
            sukset_pkg::OP_INSERT: begin
              if (hit) begin
                out_status_nxt = sukset_pkg::STAT_DUP;
              end else if (full) begin
                out_status_nxt = sukset_pkg::STAT_FULL;
              end else begin
                cmd.act   = sukset_pkg::CELL_INS;
                count_nxt = count_r + CW'(1);
              end
            end
            sukset_pkg::OP_DELETE: begin
              if (hit) begin
                cmd.act   = sukset_pkg::CELL_DEL;
                count_nxt = count_r - CW'(1);
              end else begin
                out_status_nxt = sukset_pkg::STAT_NOTFOUND;
              end
            end
            sukset_pkg::OP_SEARCH: begin
              out_status_nxt = hit ? sukset_pkg::STAT_OK : sukset_pkg::STAT_NOTFOUND;
            end
            sukset_pkg::OP_LIST: begin
              if (empty) begin
                out_status_nxt = sukset_pkg::STAT_EMPTY;
                out_key_nxt    = '0;
              end else begin
                out_valid_nxt = 1'b0;
                left_nxt      = count_r;
              end
            end
            default: out_valid_nxt = 1'b0;
          endcase
        end
      end
      sukset_pkg::CTRL_LIST: begin
        cmd.act       = sukset_pkg::CELL_ROT;
        out_valid_nxt = 1'b1;
        out_key_nxt   = head_key;
        out_last_nxt  = (left_r == CW'(1));
        left_nxt      = left_r - CW'(1);
      end
      default: cmd.act = sukset_pkg::CELL_HOLD;
    endcase
    out_count_nxt = sukset_pkg::COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sukset_pkg::CTRL_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_key    = out_key_r;
  assign out_last   = out_last_r;
  assign out_count  = out_count_r;

  `AST_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `AST_NEXT(a_list_emits, clk, rst_n, state_r == sukset_pkg::CTRL_LIST, out_valid_r, "list cycle without result")
  `AST_NEXT(a_ins_count, clk, rst_n, cmd.act == sukset_pkg::CELL_INS, count_r == $past(count_r) + CW'(1), "insert did not grow count")
  `AST_IMPL(a_rot_stable, clk, rst_n, state_r == sukset_pkg::CTRL_LIST, count_nxt == count_r, "count moved during list")

endmodule
